FILE: src/mps_pkg.sv
// ----------------------------------------------------------------------------
// mps_pkg: shared types and constants for the matrix power block
// Memory map of the matrix store, command and status records between the
// sequencer and the datapath, and the configuration register index.
// ----------------------------------------------------------------------------
package mps_pkg;

  // matrix geometry and data widths
  localparam int MAX_DIM   = 4;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = 2;
  localparam int CELL_W    = 2 * IDX_W;
  localparam int CELLS     = MAX_DIM * MAX_DIM;
  localparam int RGN_W     = 2;
  localparam int ADDR_W    = RGN_W + CELL_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int EXP_W     = 31;
  localparam int DIM_W     = 3;

  // stream and register port widths
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  // configuration register
  localparam logic               REG_DIM   = 1'b0;
  localparam logic [DIM_W-1:0]   DIM_RESET = 3'd2;

  // request kinds carried on tuser
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_RUN  = 1'b1;

  typedef logic [ADDR_W-1:0] addr_t;

  // regions of the shared matrix store
  typedef enum logic [RGN_W-1:0] {
    RGN_BASE,
    RGN_ACC,
    RGN_TEMP,
    RGN_PROD
  } region_t;

  // datapath operations
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_IDENT,
    CMD_COPY,
    CMD_MAC,
    CMD_EMIT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    addr_t     addr_a;
    addr_t     addr_b;
    addr_t     dst;
    logic      first;
    logic      last;
    logic      one;
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_empty;
    logic out_free;
  } dp_stat_t;

  function automatic addr_t cell_addr(region_t rgn, logic [IDX_W-1:0] r,
                                      logic [IDX_W-1:0] c);
    return {rgn, r, c};
  endfunction

  function automatic addr_t lin_addr(region_t rgn, logic [CELL_W-1:0] k);
    return {rgn, k};
  endfunction

endpackage

FILE: src/mps_ram.sv
// ----------------------------------------------------------------------------
// mps_ram: generic memory
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module mps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered reads
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: src/mps_ctrl.sv
// ----------------------------------------------------------------------------
// mps_ctrl: run sequencer
// Walks the square-and-multiply schedule and issues one datapath command
// per cycle unless waiting: identity fill, base copy, multiply-accumulate, copy-back, emit.
// ----------------------------------------------------------------------------
module mps_ctrl import mps_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic             req_type,
  input  logic [IDX_W-1:0] row,
  input  logic [IDX_W-1:0] col,
  input  logic [EXP_W-1:0] exponent,
  input  logic [DIM_W-1:0] dim,
  input  dp_stat_t         stat,
  output dp_cmd_t          cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_IDENT,
    S_COPY,
    S_CHECK,
    S_MAC,
    S_MACW,
    S_BACK,
    S_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [EXP_W-1:0]    exp_r, exp_nxt;
  logic [CELL_W-1:0]   k_r, k_nxt;
  logic [IDX_W-1:0]    i_r, i_nxt, j_r, j_nxt, z_r, z_nxt;
  logic                mul_r, mul_nxt;
  logic [IDX_W-1:0]    n_m1;
  region_t             dst_rgn;

  // last index of the matrix size in use, out-of-range sizes clamped
  always_comb begin
    if (dim == '0) begin
      n_m1 = '0;
    end else if (dim > DIM_W'(MAX_DIM)) begin
      n_m1 = IDX_W'(MAX_DIM - 1);
    end else begin
      n_m1 = IDX_W'(dim - DIM_W'(1));
    end
  end

  assign dst_rgn = mul_r ? RGN_ACC : RGN_TEMP;

  // next state and command
  always_comb begin
    state_nxt = state_r;
    exp_nxt   = exp_r;
    k_nxt     = k_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    z_nxt     = z_r;
    mul_nxt   = mul_r;
    cmd       = '0;
    cmd.kind  = CMD_NONE;
    in_tready = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (req_type == REQ_RUN) begin
            exp_nxt   = exponent;
            k_nxt     = '0;
            state_nxt = S_IDENT;
          end else begin
            cmd.kind = CMD_LOAD;
            cmd.dst  = cell_addr(RGN_BASE, row, col);
          end
        end
      end
      // accumulator starts as the identity
      S_IDENT: begin
        cmd.kind = CMD_IDENT;
        cmd.dst  = lin_addr(RGN_ACC, k_r);
        cmd.one  = (k_r[CELL_W-1:IDX_W] == k_r[IDX_W-1:0]);
        k_nxt    = k_r + CELL_W'(1);
        if (k_r == CELL_W'(CELLS - 1)) begin
          state_nxt = S_COPY;
        end
      end
      // working base starts as the loaded matrix
      S_COPY: begin
        cmd.kind   = CMD_COPY;
        cmd.addr_a = lin_addr(RGN_BASE, k_r);
        cmd.dst    = lin_addr(RGN_TEMP, k_r);
        k_nxt      = k_r + CELL_W'(1);
        if (k_r == CELL_W'(CELLS - 1)) begin
          state_nxt = S_CHECK;
        end
      end
      // pick multiply or square from the low exponent bit, or finish once the exponent is zero
      S_CHECK: begin
        if (stat.pipe_empty) begin
          i_nxt = '0;
          j_nxt = '0;
          z_nxt = '0;
          if (exp_r == '0) begin
            state_nxt = S_EMIT;
          end else begin
            mul_nxt   = exp_r[0];
            state_nxt = S_MAC;
          end
        end
      end
      // one multiply-accumulate per cycle over i, j, z
      S_MAC: begin
        cmd.kind   = CMD_MAC;
        cmd.addr_a = cell_addr(mul_r ? RGN_ACC : RGN_TEMP, i_r, z_r);
        cmd.addr_b = cell_addr(RGN_TEMP, z_r, j_r);
        cmd.dst    = cell_addr(RGN_PROD, i_r, j_r);
        cmd.first  = (z_r == '0);
        cmd.last   = (z_r == n_m1);
        if (z_r == n_m1) begin
          z_nxt = '0;
          if (j_r == n_m1) begin
            j_nxt = '0;
            if (i_r == n_m1) begin
              state_nxt = S_MACW;
            end else begin
              i_nxt = i_r + IDX_W'(1);
            end
          end else begin
            j_nxt = j_r + IDX_W'(1);
          end
        end else begin
          z_nxt = z_r + IDX_W'(1);
        end
      end
      // let the last sums land before copying back
      S_MACW: begin
        if (stat.pipe_empty) begin
          k_nxt     = '0;
          state_nxt = S_BACK;
        end
      end
      S_BACK: begin
        cmd.kind   = CMD_COPY;
        cmd.addr_a = lin_addr(RGN_PROD, k_r);
        cmd.dst    = lin_addr(dst_rgn, k_r);
        k_nxt      = k_r + CELL_W'(1);
        if (k_r == CELL_W'(CELLS - 1)) begin
          if (mul_r) begin
            exp_nxt = {exp_r[EXP_W-1:1], 1'b0};
          end else begin
            exp_nxt = exp_r >> 1;
          end
          state_nxt = S_CHECK;
        end
      end
      // row-major emission, one entry whenever the output slot is free
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.kind   = CMD_EMIT;
          cmd.addr_a = cell_addr(RGN_ACC, i_r, j_r);
          cmd.dst    = cell_addr(RGN_ACC, i_r, j_r);
          cmd.last   = (i_r == n_m1) && (j_r == n_m1);
          if (j_r == n_m1) begin
            j_nxt = '0;
            if (i_r == n_m1) begin
              state_nxt = S_IDLE;
            end else begin
              i_nxt = i_r + IDX_W'(1);
            end
          end else begin
            j_nxt = j_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      exp_r   <= '0;
      k_r     <= '0;
      i_r     <= '0;
      j_r     <= '0;
      z_r     <= '0;
      mul_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      exp_r   <= exp_nxt;
      k_r     <= k_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      z_r     <= z_nxt;
      mul_r   <= mul_nxt;
    end
  end

endmodule

FILE: src/mps_dp.sv
// ----------------------------------------------------------------------------
// mps_dp: matrix store, multiply-accumulate unit and output register
// Executes sequencer commands in stages: read, multiply, then accumulate
// and write back; emits result entries through a holding register.
// ----------------------------------------------------------------------------
module mps_dp import mps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  input  logic [DATA_W-1:0] ld_value,
  output dp_stat_t          stat,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [IDX_W-1:0]  out_row,
  output logic [IDX_W-1:0]  out_col,
  output logic [DATA_W-1:0] out_value,
  output logic              out_last
);

  logic [DATA_W-1:0]   rd_a, rd_b;
  logic [DATA_W-1:0]   mul_full;
  logic [DATA_W-1:0]   sum_nxt;
  logic                we;
  addr_t               waddr;
  logic [DATA_W-1:0]   wdata;
  logic                wr_mac, wr_copy, wr_ident, wr_load;

  // read stage
  cmd_kind_t           kind1_r;
  addr_t               dst1_r;
  logic                first1_r, last1_r;
  // multiply stage
  logic                mac2_r;
  addr_t               dst2_r;
  logic                first2_r, last2_r;
  logic [DATA_W-1:0]   prod_r, sum_r;
  // output holding register
  logic                out_valid_r;
  logic [IDX_W-1:0]    out_row_r, out_col_r;
  logic [DATA_W-1:0]   out_value_r;
  logic                out_last_r;

  mps_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_DEPTH)
  ) u_mem (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (cmd.addr_a),
    .rdata_a (rd_a),
    .raddr_b (cmd.addr_b),
    .rdata_b (rd_b)
  );

  // product wraps to the data width
  assign mul_full = rd_a * rd_b;
  assign sum_nxt  = (first2_r ? '0 : sum_r) + prod_r;

  // write port sources, the sequencer keeps them apart
  assign wr_mac   = mac2_r && last2_r;
  assign wr_copy  = (kind1_r == CMD_COPY);
  assign wr_ident = (cmd.kind == CMD_IDENT);
  assign wr_load  = (cmd.kind == CMD_LOAD);

  always_comb begin
    we    = 1'b1;
    waddr = cmd.dst;
    wdata = ld_value;
    if (wr_mac) begin
      waddr = dst2_r;
      wdata = sum_nxt;
    end else if (wr_copy) begin
      waddr = dst1_r;
      wdata = rd_a;
    end else if (wr_ident) begin
      wdata = cmd.one ? DATA_W'(1) : '0;
    end else if (!wr_load) begin
      we = 1'b0;
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind1_r     <= CMD_NONE;
      mac2_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.kind == CMD_COPY || cmd.kind == CMD_MAC || cmd.kind == CMD_EMIT) begin
        kind1_r <= cmd.kind;
      end else begin
        kind1_r <= CMD_NONE;
      end
      mac2_r <= (kind1_r == CMD_MAC);
      if (kind1_r == CMD_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    dst1_r   <= cmd.dst;
    first1_r <= cmd.first;
    last1_r  <= cmd.last;
    dst2_r   <= dst1_r;
    first2_r <= first1_r;
    last2_r  <= last1_r;
    prod_r   <= mul_full;
    if (mac2_r) begin
      sum_r <= sum_nxt;
    end
    if (kind1_r == CMD_EMIT) begin
      out_row_r   <= dst1_r[CELL_W-1:IDX_W];
      out_col_r   <= dst1_r[IDX_W-1:0];
      out_value_r <= rd_a;
      out_last_r  <= last1_r;
    end
  end

  assign stat.pipe_empty = (kind1_r == CMD_NONE) && !mac2_r;
  assign stat.out_free   = !out_valid_r && (kind1_r != CMD_EMIT);

  assign out_tvalid = out_valid_r;
  assign out_row    = out_row_r;
  assign out_col    = out_col_r;
  assign out_value  = out_value_r;
  assign out_last   = out_last_r;

`ifndef SYNTHESIS
  // never two writers on the single write port
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({wr_mac, wr_copy, wr_ident, wr_load}))
    else $error("write port conflict");

  // an emitted entry never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (kind1_r == CMD_EMIT) |-> !out_valid_r)
    else $error("output register overwritten");

  // a dot product streams without gaps until its last term
  a_mac_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    (mac2_r && !last2_r) |=> mac2_r)
    else $error("gap inside dot product");

  // a copy never reads a sum that is still being written
  a_copy_after_mac: assert property (@(posedge clk) disable iff (!rst_n)
    (kind1_r == CMD_COPY) |-> !mac2_r)
    else $error("copy overlaps multiply");
`endif

endmodule

FILE: src/matrix_power_by_squaring.sv
// ----------------------------------------------------------------------------
// matrix_power_by_squaring: integer matrix power by square-and-multiply
//
//   channel  dir  handshake                 payload
//   in_      in   in_tvalid / in_tready     tuser kind, tdata row/col/value/exp
//   out_     out  out_tvalid / out_tready   tdata row/col/value, tlast
//   cfg_     in   psel/penable/pwrite       dim at byte address 0
//
// A run fills the accumulator with the identity and copies the base, then
// does each multiply or square on the one shared multiply-accumulate unit,
// then emits the result entries in row-major order.
// One item is worked on at a time; in_tready is high only between runs.
// Output stalls hold the last emitted entry in the output register.
// Reset is synchronous; the matrix store needs no clearing pass.
// ----------------------------------------------------------------------------
module matrix_power_by_squaring import mps_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // input requests
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // row[1:0] col[3:2] value[35:4] exponent[66:36]
  input  logic [0:0]             in_tuser,   // req_type[0]
  // result entries
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // out_row[1:0] out_col[3:2] out_value[35:4]
  output logic                   out_tlast,
  // configuration
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  logic [DIM_W-1:0]  dim_r;
  logic              cfg_wr;
  logic              cfg_idx;
  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [IDX_W-1:0]  res_row, res_col;
  logic [DATA_W-1:0] res_value;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= DIM_RESET;
    end else if (cfg_wr && cfg_idx == REG_DIM) begin
      dim_r <= cfg_pwdata[DIM_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_idx == REG_DIM) ? CFG_DATA_W'(dim_r) : '0;

  mps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .req_type  (in_tuser[0]),
    .row       (in_tdata[1:0]),
    .col       (in_tdata[3:2]),
    .exponent  (in_tdata[66:36]),
    .dim       (dim_r),
    .stat      (stat),
    .cmd       (cmd)
  );

  mps_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .ld_value   (in_tdata[35:4]),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_row    (res_row),
    .out_col    (res_col),
    .out_value  (res_value),
    .out_last   (out_tlast)
  );

  // result packing, zero fill to whole bytes
  assign out_tdata = {{(OUT_TDATA_W - 2*IDX_W - DATA_W){1'b0}}, res_value, res_col, res_row};

endmodule
